FILE: sv/krt_pkg.sv
// Package for the keyed record table: types, codes and helpers.
package krt_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W     = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_DELETE = 3'd1,
        OP_AMEND  = 3'd2,
        OP_SEEK   = 3'd3,
        OP_SHOW   = 3'd4,
        OP_SORT   = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        SEL_NONE    = 3'd0,
        SEL_ALL     = 3'd1,
        SEL_NAME    = 3'd2,
        SEL_AGE     = 3'd3,
        SEL_SEX     = 3'd4,
        SEL_PHONE   = 3'd5,
        SEL_ADDRESS = 3'd6,
        SEL_BAD     = 3'd7
    } t_sel;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_SEL   = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  slot;
        logic [63:0] key_name;
        logic [2:0]  field_select;
        logic [63:0] new_name;
        logic [7:0]  new_age;
        logic        new_sex;
        logic [33:0] new_phone;
        logic [63:0] new_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_index;
        logic [63:0] out_name;
        logic [7:0]  out_age;
        logic        out_sex;
        logic [33:0] out_phone;
        logic [63:0] out_address;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  age;
        logic        sex;
        logic [33:0] phone;
        logic [63:0] address;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FOUND,
        S_SHIFT,
        S_AMEND,
        S_SHOW,
        S_SORT,
        S_SORT_WR,
        S_RESULT,
        S_WAIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;     // capture request
        logic clr_idx;      // index to zero
        logic inc_idx;      // index + 1
        logic wr_add;       // write request record at slot
        logic wr_amend;     // amend record at index
        logic wr_copy;      // copy index+1 into index
        logic wr_clear;     // clear record at index
        logic wr_swap;      // swap index and index+1
        logic clr_pass;     // restart sort pass
        logic dec_lim;      // shorten sort pass by one
        logic load_out;     // build result
        logic [1:0] out_status;
        logic out_rec;      // report record at index or slot, else zeros
        logic out_slot;     // found_index and record from slot, else index
        logic out_last;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_opcode opcode;
        logic    slot_ok;
        logic    sel_bad;
        logic    cur_free;
        logic    cur_match;
        logic    next_free;
        logic    idx_end;     // index at last entry
        logic    sort_swap;
        logic    pass_end;    // last compare of the pass
        logic    sort_done;
    } t_sts;

    // Cut a string at its first zero byte and at KEY_BYTES bytes.
    function automatic logic [63:0] narrow(input logic [63:0] v);
        logic [63:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b >= KEY_BYTES || v[63-8*b -: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[63-8*b -: 8] = v[63-8*b -: 8];
        end
        return r;
    endfunction

endpackage

FILE: sv/krt_datapath.sv
// Datapath of the keyed record table: record store, index, compare and result register.
module krt_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  krt_pkg::t_req i_req,
    input  krt_pkg::t_cmd i_cmd,
    output krt_pkg::t_sts o_sts,
    output krt_pkg::t_rsp o_rsp
);
    import krt_pkg::*;

    t_rec             r_tab [ENTRIES];
    t_req             r_req;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_lim;
    t_rsp             r_rsp;

    logic [IDX_W-1:0] nxt;
    t_rec             cur, nrec, amended, rep;
    logic [63:0]      key;

    assign nxt = r_idx + IDX_W'(1);
    assign cur = r_tab[r_idx];
    assign nrec = r_tab[nxt];
    assign key = narrow(r_req.key_name);
    // add reports the record at its slot, everything else the one at the index
    assign rep = i_cmd.out_slot ? r_tab[r_req.slot[IDX_W-1:0]] : cur;

    always_comb begin
        amended = cur;
        if (r_req.field_select == SEL_ALL || r_req.field_select == SEL_NAME)
            amended.name = narrow(r_req.new_name);
        if (r_req.field_select == SEL_ALL || r_req.field_select == SEL_AGE)
            amended.age = r_req.new_age;
        if (r_req.field_select == SEL_ALL || r_req.field_select == SEL_SEX)
            amended.sex = r_req.new_sex;
        if (r_req.field_select == SEL_ALL || r_req.field_select == SEL_PHONE)
            amended.phone = r_req.new_phone;
        if (r_req.field_select == SEL_ALL || r_req.field_select == SEL_ADDRESS)
            amended.address = narrow(r_req.new_address);
    end

    always_comb begin
        o_sts.opcode    = t_opcode'(r_req.opcode);
        o_sts.slot_ok   = 32'(r_req.slot) < ENTRIES;
        o_sts.sel_bad   = r_req.field_select == SEL_NONE || r_req.field_select == SEL_BAD;
        o_sts.cur_free  = cur.name == '0;
        o_sts.cur_match = cur.name == key && key != '0;
        o_sts.next_free = nrec.name == '0;
        o_sts.idx_end   = 32'(r_idx) == ENTRIES - 1;
        o_sts.sort_swap = nrec.name != '0 && cur.name > nrec.name;
        o_sts.pass_end  = nxt == r_lim;
        o_sts.sort_done = r_lim == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                r_tab[i] <= '0;
            r_idx <= '0;
            r_lim <= '0;
        end else begin
            if (i_cmd.clr_idx)
                r_idx <= '0;
            else if (i_cmd.inc_idx)
                r_idx <= nxt;
            if (i_cmd.clr_pass) begin
                r_lim <= IDX_W'(ENTRIES - 1);
            end else if (i_cmd.dec_lim) begin
                r_lim <= r_lim - IDX_W'(1);
            end
            if (i_cmd.wr_add)
                r_tab[r_req.slot[IDX_W-1:0]] <= '{narrow(r_req.new_name), r_req.new_age,
                    r_req.new_sex, r_req.new_phone, narrow(r_req.new_address)};
            if (i_cmd.wr_amend)
                r_tab[r_idx] <= amended;
            if (i_cmd.wr_copy)
                r_tab[r_idx] <= nrec;
            if (i_cmd.wr_clear)
                r_tab[r_idx] <= '0;
            if (i_cmd.wr_swap) begin
                r_tab[r_idx] <= nrec;
                r_tab[nxt]   <= cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req)
            r_req <= i_req;
        if (i_cmd.load_out) begin
            r_rsp.status      <= i_cmd.out_status;
            r_rsp.found_index <= i_cmd.out_slot ? r_req.slot :
                                 (i_cmd.out_rec ? 4'(r_idx) : 4'd0);
            r_rsp.last        <= i_cmd.out_last;
            if (i_cmd.out_rec) begin
                r_rsp.out_name    <= rep.name;
                r_rsp.out_age     <= rep.age;
                r_rsp.out_sex     <= rep.sex;
                r_rsp.out_phone   <= rep.phone;
                r_rsp.out_address <= rep.address;
            end else begin
                r_rsp.out_name    <= '0;
                r_rsp.out_age     <= '0;
                r_rsp.out_sex     <= '0;
                r_rsp.out_phone   <= '0;
                r_rsp.out_address <= '0;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: sv/krt_ctrl.sv
// Controller of the keyed record table: operation sequencer and output handshake.
module krt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  krt_pkg::t_sts i_sts,
    output krt_pkg::t_cmd o_cmd
);
    import krt_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        o_ready = 1'b0;
        if (r_valid && i_ready)
            n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.clr_idx  = 1'b1;
                    n_state        = S_ADD;
                end
            end
            S_ADD: begin
                case (i_sts.opcode)
                    OP_ADD: begin
                        o_cmd.wr_add = i_sts.slot_ok;
                        n_state      = S_RESULT;
                    end
                    OP_DELETE, OP_AMEND, OP_SEEK: n_state = S_SCAN;
                    OP_SHOW: n_state = S_SHOW;
                    OP_SORT: begin
                        o_cmd.clr_pass = 1'b1;
                        n_state        = S_SORT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_sts.cur_free) begin
                    n_state = S_WAIT;
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = ST_NOT_FOUND;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.clr_idx    = 1'b1;
                end else if (i_sts.cur_match) begin
                    n_state = S_FOUND;
                end else if (i_sts.idx_end) begin
                    n_state = S_WAIT;
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_status = ST_NOT_FOUND;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.clr_idx    = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_FOUND: begin
                if (i_sts.opcode == OP_AMEND && !i_sts.sel_bad) begin
                    o_cmd.wr_amend = 1'b1;
                    n_state        = S_AMEND;
                end else begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.out_rec    = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = (i_sts.opcode == OP_AMEND) ? ST_BAD_SEL : ST_OK;
                    if (i_sts.opcode == OP_DELETE)
                        n_state = S_SHIFT;
                    else
                        n_state = S_WAIT;
                end
            end
            S_AMEND: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_rec  = 1'b1;
                o_cmd.out_last = 1'b1;
                n_state        = S_WAIT;
            end
            S_SHIFT: begin
                if (!i_sts.idx_end && !i_sts.next_free) begin
                    o_cmd.wr_copy = 1'b1;
                    o_cmd.inc_idx = 1'b1;
                end else begin
                    o_cmd.wr_clear = 1'b1;
                    n_state        = S_WAIT;
                end
            end
            S_SHOW: begin
                if (!r_valid || i_ready) begin
                    if (i_sts.cur_free) begin
                        // only reached when slot 0 is free
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = ST_EMPTY;
                        o_cmd.out_last   = 1'b1;
                        o_cmd.clr_idx    = 1'b1;
                        n_valid          = 1'b1;
                        n_state          = S_WAIT;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_rec  = 1'b1;
                        o_cmd.out_last = i_sts.idx_end || i_sts.next_free;
                        n_valid        = 1'b1;
                        if (i_sts.idx_end || i_sts.next_free)
                            n_state = S_WAIT;
                        else
                            o_cmd.inc_idx = 1'b1;
                    end
                end
            end
            S_SORT: begin
                if (i_sts.sort_done) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_RESULT;
                end else if (i_sts.sort_swap) begin
                    o_cmd.wr_swap = 1'b1;
                    n_state       = S_SORT_WR;
                end else begin
                    n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                // advance one compare; wrap and shorten the pass at its end
                if (i_sts.pass_end) begin
                    o_cmd.clr_idx = 1'b1;
                    o_cmd.dec_lim = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
                n_state = S_SORT;
            end
            S_RESULT: begin
                o_cmd.load_out   = 1'b1;
                o_cmd.out_rec    = i_sts.opcode == OP_ADD && i_sts.slot_ok;
                o_cmd.out_slot   = i_sts.opcode == OP_ADD;
                o_cmd.out_status = ST_OK;
                o_cmd.out_last   = 1'b1;
                n_state          = S_WAIT;
            end
            S_WAIT: begin
                // single results are raised here; show has raised its own
                if (i_sts.opcode != OP_SHOW)
                    n_valid = 1'b1;
                if (!r_valid && i_sts.opcode == OP_SHOW)
                    n_state = S_IDLE;
                else if (r_valid && i_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_WAIT && r_valid && i_ready)
            n_valid = 1'b0;
    end

endmodule

FILE: sv/keyed_record_table_core.sv
// Top level of the keyed record table: controller and datapath.
// A 16-entry record table searched by name. One request runs at a time:
// seek, amend and delete walk the slots one by one (delete then moves the
// later entries up one by one), show returns one entry per response as the
// consumer takes them, and sort runs bubble passes in which each compare
// goes through S_SORT and then S_SORT_WR. The table is all free after
// reset; a zero name marks a free slot.
module keyed_record_table_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  krt_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output krt_pkg::t_rsp o_rsp
);
    import krt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    krt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    krt_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: verif/keyed_record_table_core_test.sv
// Testbench for the keyed record table: directed table plus random requests, predicted and checked.
module keyed_record_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import krt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_REQS    = 410;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;

    keyed_record_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp)
    );

    // 10 ns clock: low half, then high half.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table, advanced once per accepted request.
    t_rec table_copy [ENTRIES];
    t_rsp pending_rsps [$];
    int   mismatches = 0;
    int   idle_cycles = 0;

    // Keep string bytes up to the first zero byte; later bytes read as zero.
    function automatic logic [63:0] cut_string(logic [63:0] v);
        logic [63:0] r;
        bit stop;
        r = '0;
        stop = 1'b0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (v[63-8*b -: 8] == 8'd0) stop = 1'b1;
            if (!stop) r[63-8*b -: 8] = v[63-8*b -: 8];
        end
        return r;
    endfunction

    function automatic t_rsp make_rsp(logic [1:0] st, logic [3:0] idx, int rec, bit lst);
        t_rsp r;
        r = '0;
        r.status = st;
        r.found_index = idx;
        if (rec >= 0) begin
            r.out_name    = table_copy[rec].name;
            r.out_age     = table_copy[rec].age;
            r.out_sex     = table_copy[rec].sex;
            r.out_phone   = table_copy[rec].phone;
            r.out_address = table_copy[rec].address;
        end
        r.last = lst;
        return r;
    endfunction

    function automatic int locate_name(logic [63:0] key);
        for (int i = 0; i < ENTRIES && table_copy[i].name != 0; i++)
            if (table_copy[i].name == key) return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and queue the responses it makes.
    function automatic void apply_request(t_req q);
        logic [63:0] key, nname, naddr;
        int k, j, cnt;
        t_rec t;
        key   = cut_string(q.key_name);
        nname = cut_string(q.new_name);
        naddr = cut_string(q.new_address);
        case (q.opcode)
            OP_ADD: begin
                if (q.slot < ENTRIES) begin
                    table_copy[q.slot] = '{nname, q.new_age, q.new_sex, q.new_phone, naddr};
                    pending_rsps.push_back(make_rsp(ST_OK, q.slot, q.slot, 1'b1));
                end else
                    pending_rsps.push_back(make_rsp(ST_OK, q.slot, -1, 1'b1));
            end
            OP_DELETE: begin
                k = locate_name(key);
                if (k < 0)
                    pending_rsps.push_back(make_rsp(ST_NOT_FOUND, 0, -1, 1'b1));
                else begin
                    pending_rsps.push_back(make_rsp(ST_OK, 4'(k), k, 1'b1));
                    j = k;
                    while (j + 1 < ENTRIES && table_copy[j+1].name != 0) begin
                        table_copy[j] = table_copy[j+1];
                        j++;
                    end
                    table_copy[j] = '0;
                end
            end
            OP_AMEND: begin
                k = locate_name(key);
                if (k < 0)
                    pending_rsps.push_back(make_rsp(ST_NOT_FOUND, 0, -1, 1'b1));
                else if (q.field_select == SEL_NONE || q.field_select == SEL_BAD)
                    pending_rsps.push_back(make_rsp(ST_BAD_SEL, 4'(k), k, 1'b1));
                else begin
                    if (q.field_select inside {SEL_ALL, SEL_NAME}) table_copy[k].name = nname;
                    if (q.field_select inside {SEL_ALL, SEL_AGE}) table_copy[k].age = q.new_age;
                    if (q.field_select inside {SEL_ALL, SEL_SEX}) table_copy[k].sex = q.new_sex;
                    if (q.field_select inside {SEL_ALL, SEL_PHONE})
                        table_copy[k].phone = q.new_phone;
                    if (q.field_select inside {SEL_ALL, SEL_ADDRESS})
                        table_copy[k].address = naddr;
                    pending_rsps.push_back(make_rsp(ST_OK, 4'(k), k, 1'b1));
                end
            end
            OP_SEEK: begin
                k = locate_name(key);
                if (k < 0) pending_rsps.push_back(make_rsp(ST_NOT_FOUND, 0, -1, 1'b1));
                else       pending_rsps.push_back(make_rsp(ST_OK, 4'(k), k, 1'b1));
            end
            OP_SHOW: begin
                cnt = 0;
                while (cnt < ENTRIES && table_copy[cnt].name != 0) cnt++;
                if (cnt == 0)
                    pending_rsps.push_back(make_rsp(ST_EMPTY, 0, -1, 1'b1));
                for (int i = 0; i < cnt; i++)
                    pending_rsps.push_back(make_rsp(ST_OK, 4'(i), i, i == cnt - 1));
            end
            OP_SORT: begin
                for (int i = 0; i < ENTRIES - 1; i++)
                    for (int m = 0; m < ENTRIES - 1 - i; m++)
                        if (table_copy[m+1].name != 0 &&
                            table_copy[m].name > table_copy[m+1].name) begin
                            t = table_copy[m];
                            table_copy[m] = table_copy[m+1];
                            table_copy[m+1] = t;
                        end
                pending_rsps.push_back(make_rsp(ST_OK, 0, -1, 1'b1));
            end
            default: ;  // undefined opcodes: no change, no response
        endcase
    endfunction

    // Names from a small pool so that searches hit often; some with inner zeros.
    function automatic logic [63:0] pick_name();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {$urandom, $urandom};
            1: v = 64'd0;
            2: v = {8'h41 + 8'($urandom_range(0, 5)), 8'h00, 48'($urandom)};
            default: v = {8'h41 + 8'($urandom_range(0, 5)),
                          8'h61 + 8'($urandom_range(0, 1)), 48'd0};
        endcase
        return v;
    endfunction

    function automatic t_req random_request();
        t_req q;
        int pick;
        q.slot         = 4'($urandom_range(0, 15));
        q.key_name     = pick_name();
        q.field_select = 3'($urandom_range(0, 7));
        q.new_name     = pick_name();
        q.new_age      = 8'($urandom);
        q.new_sex      = 1'($urandom);
        q.new_phone    = 34'({$urandom, $urandom});
        q.new_address  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        // Mostly adds and searches; sort and show less often, stray opcodes rarely.
        if (pick < 30)      q.opcode = OP_ADD;
        else if (pick < 45) q.opcode = OP_DELETE;
        else if (pick < 62) q.opcode = OP_AMEND;
        else if (pick < 80) q.opcode = OP_SEEK;
        else if (pick < 90) q.opcode = OP_SHOW;
        else if (pick < 97) q.opcode = OP_SORT;
        else                q.opcode = 3'($urandom_range(6, 7));
        return q;
    endfunction

    // Directed rows; a typed-in response is checked in place of the prediction.
    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_row;
    t_row directed_rows [$];

    function automatic t_req row_req(t_opcode op, logic [3:0] slot, logic [63:0] key,
                                     t_sel sel, logic [63:0] nm, logic [7:0] age,
                                     logic sex, logic [33:0] ph, logic [63:0] addr);
        t_req q;
        q = '{op, slot, key, sel, nm, age, sex, ph, addr};
        return q;
    endfunction

    function automatic t_rsp fixed_rsp(t_status st, logic [3:0] idx, logic [63:0] nm,
                                       logic [7:0] age, logic sex, logic [33:0] ph,
                                       logic [63:0] addr);
        t_rsp r;
        r = '{st, idx, nm, age, sex, ph, addr, 1'b1};
        return r;
    endfunction

    initial begin
        t_row r;
        // Empty table: show reports empty, seek misses.
        r = '{row_req(OP_SHOW, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_EMPTY, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        r = '{row_req(OP_SEEK, 0, 64'h4100_0000_0000_0000, SEL_NONE, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        // Extremes: all-ones fields at slot 15, full 8-byte name.
        r = '{row_req(OP_ADD, 15, 0, SEL_NONE, '1, 8'hFF, 1, '1, '1), 1,
              fixed_rsp(ST_OK, 15, '1, 8'hFF, 1, '1, '1)};
        directed_rows.push_back(r);
        r = '{row_req(OP_ADD, 0, 0, SEL_NONE, 64'h5A5A_0000_1234_0000, 0, 0, 0,
                      64'h4142_0043_0000_0000), 1,
              fixed_rsp(ST_OK, 0, 64'h5A5A_0000_0000_0000, 0, 0, 0,
                        64'h4142_0000_0000_0000)};
        directed_rows.push_back(r);
        r = '{row_req(OP_ADD, 1, 0, SEL_NONE, 64'h4100_0000_0000_0000, 42, 1,
                      34'd9999999999, 64'h0102_0304_0506_0708), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(OP_ADD, 2, 0, SEL_NONE, 64'h0100_0000_0000_0000, 7, 0, 1,
                      64'h2000_0000_0000_0000), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(OP_SHOW, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(OP_SEEK, 0, 64'h4100_0000_0000_0000, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        // Zero key never matches.
        r = '{row_req(OP_SEEK, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        // Bad selectors on a hit, then every good selector.
        r = '{row_req(OP_AMEND, 0, 64'h4100_0000_0000_0000, SEL_NONE, 1, 1, 1, 1, 1), 1,
              fixed_rsp(ST_BAD_SEL, 1, 64'h4100_0000_0000_0000, 42, 1, 34'd9999999999,
                        64'h0102_0304_0506_0708)};
        directed_rows.push_back(r);
        r = '{row_req(OP_AMEND, 0, 64'h4100_0000_0000_0000, SEL_BAD, 1, 1, 1, 1, 1), 0, '0};
        directed_rows.push_back(r);
        for (int s = SEL_AGE; s <= SEL_ADDRESS; s++) begin
            r = '{row_req(OP_AMEND, 0, 64'h4100_0000_0000_0000, t_sel'(s),
                          64'h7700_0000_0000_0000, 8'h80, 0, 34'h2_0000_0000,
                          64'hFF00_0000_0000_0000), 0, '0};
            directed_rows.push_back(r);
        end
        r = '{row_req(OP_AMEND, 0, 64'h4100_0000_0000_0000, SEL_NAME,
                      64'h4300_0000_0000_0000, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(OP_AMEND, 0, 64'h4300_0000_0000_0000, SEL_ALL,
                      64'h4400_0000_0000_0000, 3, 1, 5, 64'h4500_0000_0000_0000), 0, '0};
        directed_rows.push_back(r);
        // Miss on amend and delete; slots 3..14 stay free so show ends at slot 2.
        r = '{row_req(OP_AMEND, 0, 64'h9900_0000_0000_0000, SEL_ALL, 1, 1, 1, 1, 1), 1,
              fixed_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        r = '{row_req(OP_DELETE, 0, 64'h9900_0000_0000_0000, SEL_NONE, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        r = '{row_req(OP_SORT, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_OK, 0, 0, 0, 0, 0, 0)};
        directed_rows.push_back(r);
        r = '{row_req(OP_SHOW, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        // Delete in the middle shifts later entries up; undefined opcode is dropped.
        r = '{row_req(OP_DELETE, 0, 64'h4400_0000_0000_0000, SEL_NONE, 0, 0, 0, 0, 0),
              0, '0};
        directed_rows.push_back(r);
        r = '{row_req(t_opcode'(3'd6), 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(t_opcode'(3'd7), 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
        // Adding a zero name frees the slot.
        r = '{row_req(OP_ADD, 0, 0, SEL_NONE, 0, 9, 1, 9, 9), 0, '0};
        directed_rows.push_back(r);
        r = '{row_req(OP_SHOW, 0, 0, SEL_NONE, 0, 0, 0, 0, 0), 0, '0};
        directed_rows.push_back(r);
    end

    // Sender: hold valid with the request until accepted, in bursts with gaps.
    int burst_left = 0;

    task automatic send_request(t_req q, bit fixed, t_rsp want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_req   <= q;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        // Predict at acceptance so the shadow table tracks the block's order.
        apply_request(q);
        if (fixed) begin
            void'(pending_rsps.pop_back());
            pending_rsps.push_back(want);
        end
    endtask

    // Drop valid once the last request has been taken.
    task automatic stop_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Receiver: stall on a pattern that switches between modes.
    int stall_mode = 0;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ($urandom_range(0, 19) != 0) ? i_ready : ~i_ready;
        endcase
    end

    // Compare each response with the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", o_rsp);
            end else begin
                want = pending_rsps.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_rsp);
                end
            end
        end
    end

    // Watchdog: count cycles in which no request or response moves.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) table_copy[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_rows[n])
            send_request(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].rsp);
        for (int n = 0; n < RANDOM_REQS; n++) begin
            // Hold off now and then until every response has come back.
            if (n % 100 == 50) begin
                stop_sending();
                wait (pending_rsps.size() == 0);
            end
            send_request(random_request(), 1'b0, '0);
        end
        stop_sending();
        wait (pending_rsps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: keyed_record_table_core.f
sv/krt_pkg.sv
sv/krt_datapath.sv
sv/krt_ctrl.sv
sv/keyed_record_table_core.sv
verif/keyed_record_table_core_test.sv
